// ----- hw/rtl/irn_pkg.sv -----
`timescale 1ns / 1ps

package irn_pkg;

  localparam int NUM_W = 12;
  localparam int CHAR_W = 7;
  localparam int PC_W = 5;
  localparam logic [NUM_W-1:0] NUM_MAX = 12'd3999;
  localparam logic [CHAR_W-1:0] CH_NL = 7'd10;

  // micro-op codes
  localparam logic [1:0] OP_SUB  = 2'd0;  // rem >= value: emit ch, subtract, go hit; else go miss
  localparam logic [1:0] OP_EMIT = 2'd1;  // emit ch, go hit
  localparam logic [1:0] OP_END  = 2'd2;  // emit newline with last, go idle

  localparam logic [PC_W-1:0] PC_START = 5'd0;

  typedef struct packed {
    logic [1:0]        op;
    logic [NUM_W-1:0]  value;
    logic [CHAR_W-1:0] ch;
    logic [PC_W-1:0]   hit;
    logic [PC_W-1:0]   miss;
  } uword_t;

  // sequencer -> datapath
  typedef struct packed {
    logic              load;
    logic              emit;
    logic              sub;
    logic [NUM_W-1:0]  value;
    logic [CHAR_W-1:0] ch;
    logic              last;
  } ctl_t;

  // datapath -> sequencer
  typedef struct packed {
    logic ge;
    logic can_emit;
  } sts_t;

  function automatic uword_t mk(input logic [1:0] op, input int value, input byte ch,
                                input int hit, input int miss);
    uword_t w;
    w.op    = op;
    w.value = value[NUM_W-1:0];
    w.ch    = ch[CHAR_W-1:0];
    w.hit   = hit[PC_W-1:0];
    w.miss  = miss[PC_W-1:0];
    return w;
  endfunction

  // Greedy numeral program: each symbol value is subtracted while it fits.
  // Subtractive pairs put their second letter in a following EMIT step.
  function automatic uword_t ucode(input logic [PC_W-1:0] addr);
    uword_t w;
    case (addr)
      5'd0:    w = mk(OP_SUB,  1000, "M", 0, 1);
      5'd1:    w = mk(OP_SUB,  900,  "C", 2, 3);
      5'd2:    w = mk(OP_EMIT, 0,    "M", 3, 3);
      5'd3:    w = mk(OP_SUB,  500,  "D", 4, 4);
      5'd4:    w = mk(OP_SUB,  400,  "C", 5, 6);
      5'd5:    w = mk(OP_EMIT, 0,    "D", 6, 6);
      5'd6:    w = mk(OP_SUB,  100,  "C", 6, 7);
      5'd7:    w = mk(OP_SUB,  90,   "X", 8, 9);
      5'd8:    w = mk(OP_EMIT, 0,    "C", 9, 9);
      5'd9:    w = mk(OP_SUB,  50,   "L", 10, 10);
      5'd10:   w = mk(OP_SUB,  40,   "X", 11, 12);
      5'd11:   w = mk(OP_EMIT, 0,    "L", 12, 12);
      5'd12:   w = mk(OP_SUB,  10,   "X", 12, 13);
      5'd13:   w = mk(OP_SUB,  9,    "I", 14, 15);
      5'd14:   w = mk(OP_EMIT, 0,    "X", 15, 15);
      5'd15:   w = mk(OP_SUB,  5,    "V", 16, 16);
      5'd16:   w = mk(OP_SUB,  4,    "I", 17, 18);
      5'd17:   w = mk(OP_EMIT, 0,    "V", 18, 18);
      5'd18:   w = mk(OP_SUB,  1,    "I", 18, 19);
      default: w = mk(OP_END,  0,    8'd10, 0, 0);
    endcase
    return w;
  endfunction

endpackage

// ----- hw/rtl/irn_seq.sv -----
`timescale 1ns / 1ps

module irn_seq
  import irn_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  sts_t sts,
  output ctl_t ctl
);

  logic            busy, busy_next;
  logic [PC_W-1:0] pc, pc_next;
  uword_t          uw;

  assign uw = ucode(pc);
  assign in_ready = !busy;

  always_comb begin
    ctl       = '0;
    ctl.value = uw.value;
    ctl.ch    = (uw.op == OP_END) ? CH_NL : uw.ch;
    ctl.last  = (uw.op == OP_END);
    pc_next   = pc;
    busy_next = busy;
    if (!busy) begin
      if (in_valid) begin
        ctl.load  = 1'b1;
        busy_next = 1'b1;
        pc_next   = PC_START;
      end
    end else begin
      case (uw.op)
        OP_SUB: begin
          if (sts.ge) begin
            if (sts.can_emit) begin
              ctl.emit = 1'b1;
              ctl.sub  = 1'b1;
              pc_next  = uw.hit;
            end
          end else begin
            pc_next = uw.miss;
          end
        end
        OP_EMIT: begin
          if (sts.can_emit) begin
            ctl.emit = 1'b1;
            pc_next  = uw.hit;
          end
        end
        OP_END: begin
          if (sts.can_emit) begin
            ctl.emit  = 1'b1;
            busy_next = 1'b0;
          end
        end
        default: begin
          busy_next = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      pc   <= PC_START;
    end else begin
      busy <= busy_next;
      pc   <= pc_next;
    end
  end

endmodule

// ----- hw/rtl/irn_datapath.sv -----
`timescale 1ns / 1ps

module irn_datapath
  import irn_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic [NUM_W-1:0]  number,
  input  ctl_t              ctl,
  output sts_t              sts,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [CHAR_W-1:0] character,
  output logic              last
);

  logic [NUM_W-1:0] rem;

  assign sts.ge       = (rem >= ctl.value);
  assign sts.can_emit = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      rem <= (number > NUM_MAX) ? NUM_MAX : number;
    end else if (ctl.sub) begin
      rem <= rem - ctl.value;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctl.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.emit) begin
      character <= ctl.ch;
      last      <= ctl.last;
    end
  end

endmodule

// ----- hw/rtl/integer_to_roman_numeral_core.sv -----
`timescale 1ns / 1ps
// Integer to Roman numeral converter.
// Input channel (in_valid/in_ready, number): one 12-bit unsigned value per
// transaction; values above 3999 are treated as 3999.
// Output channel (out_valid/out_ready, character, last): the numeral as a
// run of 7-bit ASCII letters, one per transaction, closed by a newline
// (10) with last set. Zero yields only the newline.
// A microcoded sequencer walks a 20-step program of symbol values
// (1000, 900, 500, ... 1); each step either emits a letter and subtracts,
// or moves on; the M, C, X and I steps repeat while their value still fits.
// Input is loaded first, then the steps run in order; each letter is
// registered in the output register by the step that emits it.
// in_ready is high only while no conversion is running; the next number is
// taken in the cycle after the newline enters the output register.
// When the receiver stalls, the output register holds its letter and the
// sequencer waits at the next step that has a letter to emit.
// Reset (rst, synchronous) empties the output register and idles the
// sequencer.

module integer_to_roman_numeral_core
  import irn_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [NUM_W-1:0]  number,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [CHAR_W-1:0] character,
  output logic              last
);

  ctl_t ctl;
  sts_t sts;

  irn_seq u_seq (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .ctl      (ctl)
  );

  irn_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .number    (number),
    .ctl       (ctl),
    .sts       (sts),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .character (character),
    .last      (last)
  );

endmodule

// ----- hw/rtl/irn_checker.sv -----
`timescale 1ns / 1ps

module irn_checker
  import irn_pkg::*;
(
  input logic              clk,
  input logic              rst,
  input logic              in_valid,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input logic [CHAR_W-1:0] character,
  input logic              last
);

  // one conversion at a time
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("in_ready stayed high after an input transaction");

  // becoming ready again coincides with the newline being presented
  a_ready_on_newline: assert property (@(posedge clk) disable iff (rst)
    $rose(in_ready) |-> out_valid && last)
    else $error("in_ready rose without a pending newline");

  a_legal_char: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (last && character == CH_NL) ||
                  (!last && (character == 7'h49 || character == 7'h56 ||
                             character == 7'h58 || character == 7'h4C ||
                             character == 7'h43 || character == 7'h44 ||
                             character == 7'h4D)))
    else $error("illegal character or last flag");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(character) && $stable(last))
    else $error("output changed while stalled");

endmodule

bind integer_to_roman_numeral_core irn_checker u_irn_checker (.*);
